// File: rtl/core/cie_pkg.sv
// ----------------------------------------------------------------------------
// cie_pkg
// Shared codes, constants and transaction types of the CPU8 instruction
// encoder.
// ----------------------------------------------------------------------------
package cie_pkg;

   // Memory size and address counter
   localparam int              MemoryBytes = 256;
   localparam int              AddrWidth   = 9;
   localparam logic [AddrWidth-1:0] MEM_LIMIT = AddrWidth'(MemoryBytes);

   // Mnemonic codes
   localparam logic [4:0] M_HLT     = 5'd0;
   localparam logic [4:0] M_NOP     = 5'd1;
   localparam logic [4:0] M_RET     = 5'd2;
   localparam logic [4:0] M_JC      = 5'd3;
   localparam logic [4:0] M_JN      = 5'd4;
   localparam logic [4:0] M_JZ      = 5'd5;
   localparam logic [4:0] M_JO      = 5'd6;
   localparam logic [4:0] M_LITERAL = 5'd7;
   localparam logic [4:0] M_JMP     = 5'd8;
   localparam logic [4:0] M_PUSH    = 5'd9;
   localparam logic [4:0] M_POP     = 5'd10;
   localparam logic [4:0] M_CALL    = 5'd11;
   localparam logic [4:0] M_NOT     = 5'd12;
   localparam logic [4:0] M_INC     = 5'd13;
   localparam logic [4:0] M_DEC     = 5'd14;
   localparam logic [4:0] M_TST     = 5'd15;
   localparam logic [4:0] M_MOV     = 5'd16;
   localparam logic [4:0] M_DATA    = 5'd17;
   localparam logic [4:0] M_LOD     = 5'd18;
   localparam logic [4:0] M_STO     = 5'd19;
   localparam logic [4:0] M_ADD     = 5'd20;
   localparam logic [4:0] M_ADC     = 5'd21;
   localparam logic [4:0] M_SUB     = 5'd22;
   localparam logic [4:0] M_SBC     = 5'd23;
   localparam logic [4:0] M_AND     = 5'd24;
   localparam logic [4:0] M_OR      = 5'd25;
   localparam logic [4:0] M_XOR     = 5'd26;
   localparam logic [4:0] M_CMP     = 5'd27;

   // Operand kinds
   localparam logic [1:0] KIND_NONE = 2'd0;
   localparam logic [1:0] KIND_REG  = 2'd1;

   // Register codes
   localparam logic [2:0] REG_RB = 3'd1;
   localparam logic [2:0] REG_RC = 3'd2;
   localparam logic [2:0] REG_PC = 3'd5;

   // Opcode byte fields
   localparam logic [7:0] GRP_LOAD  = 8'b0100_0000;
   localparam logic [7:0] GRP_STORE = 8'b1000_0000;
   localparam logic [7:0] GRP_ARITH = 8'b1100_0000;
   localparam logic [7:0] DST_IMM   = 8'b0011_1000;
   localparam logic [7:0] DST_SPI   = 8'b0011_0000;
   localparam logic [7:0] CARRY_BIT = 8'b0010_0000;
   localparam logic [2:0] SRC_IMM   = 3'b111;
   localparam logic [2:0] SRC_SPI   = 3'b110;
   localparam logic [2:0] COND_Z    = 3'b001;
   localparam logic [2:0] COND_N    = 3'b010;
   localparam logic [2:0] COND_O    = 3'b100;

   // ALU select codes (bits 4:2)
   localparam logic [2:0] ALU_ADD = 3'd3;
   localparam logic [2:0] ALU_SUB = 3'd2;
   localparam logic [2:0] ALU_XOR = 3'd4;
   localparam logic [2:0] ALU_OR  = 3'd5;
   localparam logic [2:0] ALU_AND = 3'd6;
   localparam logic [2:0] ALU_NOT = 3'd7;

   // Byte lengths
   localparam logic [1:0] LEN_NONE = 2'd0;
   localparam logic [1:0] LEN_ONE  = 2'd1;
   localparam logic [1:0] LEN_TWO  = 2'd2;

   // Error codes
   localparam logic [3:0] ERR_OK         = 4'd0;
   localparam logic [3:0] ERR_TWO_IMM    = 4'd1;
   localparam logic [3:0] ERR_NO_OPND    = 4'd2;
   localparam logic [3:0] ERR_JCC        = 4'd3;
   localparam logic [3:0] ERR_JMP_PUSH   = 4'd4;
   localparam logic [3:0] ERR_POP        = 4'd5;
   localparam logic [3:0] ERR_CALL       = 4'd6;
   localparam logic [3:0] ERR_UNARY      = 4'd7;
   localparam logic [3:0] ERR_MOV        = 4'd8;
   localparam logic [3:0] ERR_DATA       = 4'd9;
   localparam logic [3:0] ERR_LOD        = 4'd10;
   localparam logic [3:0] ERR_STO        = 4'd11;
   localparam logic [3:0] ERR_BINARY     = 4'd12;
   localparam logic [3:0] ERR_UNKNOWN    = 4'd13;
   localparam logic [3:0] ERR_OVERFLOW   = 4'd14;

   typedef struct packed {
      logic [7:0] immediate;
      logic [2:0] register;
      logic       indirect;
      logic [1:0] kind;
   } operand_type;

   typedef struct packed {
      operand_type right;
      operand_type left;
      logic [4:0]  mnemonic;
   } instr_type;

   typedef struct packed {
      logic [3:0] error_code;
      logic [1:0] byte_length;
      logic [7:0] immediate_byte;
      logic [7:0] opcode_byte;
      logic [7:0] placed_address;
   } result_type;

endpackage

// File: rtl/core/cie_encode.sv
// ----------------------------------------------------------------------------
// cie_encode
// Operand rule check, overflow check and opcode/immediate encoding of one
// instruction against the current placement address.
// ----------------------------------------------------------------------------
module cie_encode (
   input  cie_pkg::instr_type                   instr,
   input  logic [cie_pkg::AddrWidth-1:0]        next_address,
   output cie_pkg::result_type                  result
);
   import cie_pkg::*;

   logic [3:0] rule_err;
   logic [3:0] err;
   logic [7:0] op;
   logic       l_none, l_reg, l_imm, l_alu;
   logic       r_none, r_reg, r_imm, r_alu;
   logic [4:0] m;

   assign m      = instr.mnemonic;
   assign l_none = (instr.left.kind == KIND_NONE);
   assign l_reg  = (instr.left.kind == KIND_REG);
   assign l_imm  = instr.left.kind[1];
   assign l_alu  = !instr.left.indirect && l_reg && !instr.left.register[2];
   assign r_none = (instr.right.kind == KIND_NONE);
   assign r_reg  = (instr.right.kind == KIND_REG);
   assign r_imm  = instr.right.kind[1];
   assign r_alu  = !instr.right.indirect && r_reg && !instr.right.register[2];

   // Operand rules, two-immediate check first
   always_comb begin
      rule_err = ERR_OK;
      if (l_imm && r_imm) begin
         rule_err = ERR_TWO_IMM;
      end else begin
         unique case (m) inside
            M_HLT, M_NOP, M_RET: begin
               if (!l_none || !r_none) rule_err = ERR_NO_OPND;
            end
            M_JC, M_JN, M_JZ, M_JO, M_LITERAL: begin
               if (!r_none || !l_imm || instr.left.indirect) rule_err = ERR_JCC;
            end
            M_JMP, M_PUSH: begin
               if (l_none || !r_none || instr.left.indirect) rule_err = ERR_JMP_PUSH;
            end
            M_POP: begin
               if (!l_reg || !r_none || instr.left.indirect) rule_err = ERR_POP;
            end
            M_CALL: begin
               if (!l_reg || !r_none || instr.left.indirect ||
                   instr.left.register != REG_RC) rule_err = ERR_CALL;
            end
            M_NOT, M_INC, M_DEC, M_TST: begin
               if (!l_alu || !r_none) rule_err = ERR_UNARY;
            end
            M_MOV: begin
               if (!l_reg || instr.left.indirect || !r_reg || instr.right.indirect)
                  rule_err = ERR_MOV;
            end
            M_DATA: begin
               if (!l_reg || instr.left.indirect || !r_imm || instr.right.indirect)
                  rule_err = ERR_DATA;
            end
            M_LOD: begin
               if (!l_reg || instr.left.indirect || r_none || !instr.right.indirect)
                  rule_err = ERR_LOD;
            end
            M_STO: begin
               if (l_none || !instr.left.indirect || r_none || instr.right.indirect)
                  rule_err = ERR_STO;
            end
            M_ADD, M_ADC, M_SUB, M_SBC, M_AND, M_OR, M_XOR, M_CMP: begin
               if (!l_alu || !r_alu || instr.right.register != REG_RB)
                  rule_err = ERR_BINARY;
            end
            default: rule_err = ERR_UNKNOWN;
         endcase
      end
   end

   assign err = (rule_err == ERR_OK && next_address >= MEM_LIMIT) ? ERR_OVERFLOW : rule_err;

   // Opcode byte: group, destination, source, ALU select
   always_comb begin
      op = '0;
      unique case (m) inside
         M_LOD, M_POP, M_RET: op = GRP_LOAD;
         M_STO, M_PUSH, M_CALL: op = GRP_STORE;
         M_ADD, M_ADC, M_SUB, M_SBC, M_INC, M_DEC,
         M_XOR, M_OR, M_AND, M_NOT, M_CMP, M_TST: op = GRP_ARITH;
         default: ;
      endcase

      unique case (m) inside
         M_MOV, M_LOD, M_STO, M_POP, M_DATA:
            op = op | (l_imm ? DST_IMM : {2'b00, instr.left.register, 3'b000});
         M_PUSH, M_CALL: op = op | DST_SPI;
         M_JMP, M_RET, M_HLT: op = op | {2'b00, REG_PC, 3'b000};
         M_NOP: ;
         M_JZ, M_JO, M_JN, M_JC: op = op | DST_IMM;
         default: op = op | {5'b00000, instr.left.register};
      endcase

      unique case (m) inside
         M_MOV, M_LOD, M_STO, M_DATA:
            op = op | {5'b00000, (r_imm ? SRC_IMM : instr.right.register)};
         M_PUSH, M_JMP:
            op = op | {5'b00000, (l_imm ? SRC_IMM : instr.left.register)};
         M_CALL, M_HLT: op = op | {5'b00000, REG_PC};
         M_POP, M_RET: op = op | {5'b00000, SRC_SPI};
         M_JZ: op = op | {5'b00000, COND_Z};
         M_JO: op = op | {5'b00000, COND_O};
         M_JN: op = op | {5'b00000, COND_N};
         default: ;
      endcase

      unique case (m) inside
         M_ADD: op = op | {3'b000, ALU_ADD, 2'b00};
         M_ADC: op = op | CARRY_BIT | {3'b000, ALU_ADD, 2'b00};
         M_TST: op = op | CARRY_BIT | {3'b000, ALU_NOT, 2'b00};
         M_SUB: op = op | {3'b000, ALU_SUB, 2'b00};
         M_SBC: op = op | CARRY_BIT | {3'b000, ALU_SUB, 2'b00};
         M_CMP: op = op | CARRY_BIT | {3'b000, ALU_AND, 2'b00};
         M_DEC: op = op | CARRY_BIT;
         M_XOR: op = op | {3'b000, ALU_XOR, 2'b00};
         M_OR:  op = op | {3'b000, ALU_OR, 2'b00};
         M_AND: op = op | {3'b000, ALU_AND, 2'b00};
         M_NOT: op = op | {3'b000, ALU_NOT, 2'b00};
         default: ;
      endcase
   end

   always_comb begin
      result = '0;
      result.error_code = err;
      if (err == ERR_OK) begin
         result.placed_address = next_address[7:0];
         if (m == M_LITERAL) begin
            result.opcode_byte = instr.left.immediate;
            result.byte_length = LEN_ONE;
         end else begin
            result.opcode_byte = op;
            // Right immediate wins when both are present (never passes the rules)
            if (r_imm) begin
               result.immediate_byte = instr.right.immediate;
            end else if (l_imm) begin
               result.immediate_byte = instr.left.immediate;
            end
            result.byte_length = (l_imm || r_imm) ? LEN_TWO : LEN_ONE;
         end
      end
   end

endmodule

// File: rtl/core/cpu8_instruction_encoder_unit.sv
// ----------------------------------------------------------------------------
// cpu8_instruction_encoder_unit
// Checks and encodes parsed CPU8 instructions and places them in memory.
// ----------------------------------------------------------------------------
// One instruction transaction is accepted per cycle unless the input stalls.
// Its result passes through the input register, then the result register,
// which captures it once the result side is free, and is then offered on
// rsp. The input stalls only while both registers hold a transaction
// and the result side is not ready. The placement counter is read and
// advanced within the single stage between the two registers, so
// back-to-back instructions see each other's address without stalls. A
// rejected instruction returns its error code with all other fields zero and
// leaves the counter untouched; an instruction that passes the operand rules
// but starts at or beyond the end of memory is rejected as an overflow.
module cpu8_instruction_encoder_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [4:0] mnemonic, [6:5] left_kind, [7] left_indirect, [10:8] left_register,
   // [18:11] left_immediate, [20:19] right_kind, [21] right_indirect,
   // [24:22] right_register, [32:25] right_immediate, [39:33] zero
   input  logic [39:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [7:0] placed_address, [15:8] opcode_byte, [23:16] immediate_byte,
   // [25:24] byte_length, [29:26] error_code, [31:30] zero
   output logic [31:0] rsp_tdata
);
   import cie_pkg::*;

   logic                 s1_valid_ff, s1_valid_in;
   instr_type            s1_instr_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   result_type           rsp_data_ff;
   logic [AddrWidth-1:0] next_addr_ff, next_addr_in;
   result_type           result;
   logic                 out_free;
   logic                 load;
   logic                 req_take;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign load       = s1_valid_ff && out_free;
   assign req_tready = !s1_valid_ff || out_free;
   assign req_take   = req_tvalid && req_tready;

   cie_encode u_encode (
      .instr        (s1_instr_ff),
      .next_address (next_addr_ff),
      .result       (result)
   );

   // Error results carry zero length, so the counter holds on its own
   assign next_addr_in = load ? next_addr_ff + AddrWidth'(result.byte_length) : next_addr_ff;
   assign s1_valid_in  = req_take ? 1'b1 : (out_free ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = out_free ? s1_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         next_addr_ff <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         next_addr_ff <= next_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_instr_ff <= req_tdata[$bits(instr_type)-1:0];
      end
      if (load) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(32-$bits(result_type)){1'b0}}, rsp_data_ff};

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.error_code != ERR_OK) |->
         (rsp_data_ff.byte_length == LEN_NONE && rsp_data_ff.opcode_byte == 8'h00 &&
          rsp_data_ff.placed_address == 8'h00))
      else $error("error result carries nonzero fields");

   a_ok_len: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.error_code == ERR_OK) |->
         (rsp_data_ff.byte_length == LEN_ONE || rsp_data_ff.byte_length == LEN_TWO))
      else $error("good result without a length");

   a_err_hold: assert property (@(posedge clock) disable iff (reset)
      (load && result.error_code != ERR_OK) |=> $stable(next_addr_ff))
      else $error("placement address moved on a rejected instruction");

   a_addr_idle: assert property (@(posedge clock) disable iff (reset)
      !load |=> $stable(next_addr_ff))
      else $error("placement address moved without a result");

   a_stall: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (s1_valid_ff && rsp_valid_ff))
      else $error("input stalled with a free stage");

endmodule
